// File: design/ray_box_nearest_hit_defines.svh
// Assertion macros used by the checker file.
`ifndef RAY_BOX_NEAREST_HIT_DEFINES_SVH
`define RAY_BOX_NEAREST_HIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RBNH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RBNH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/rbnh_pkg.sv
// Types, constants and helpers of the ray/box nearest hit block.
package rbnh_pkg;

  localparam int unsigned MAX_BOXES  = 1024;
  localparam int unsigned CNT_W      = $clog2(MAX_BOXES + 2);
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned EXT_W      = 31;
  localparam int unsigned OFF_W      = DATA_W + 2;
  localparam int unsigned PROD_W     = 2 * DATA_W;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned PIPE_DEPTH = 4;
  localparam int unsigned OCC_W      = $clog2(FIFO_DEPTH + PIPE_DEPTH + 1);
  localparam logic signed [DATA_W-1:0] INV_DIR_RESET = DATA_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_ORIGIN_Z  = 3'd2,
    REG_INV_DIR_X = 3'd3,
    REG_INV_DIR_Y = 3'd4,
    REG_INV_DIR_Z = 3'd5
  } cfg_reg_e;

  // Per-box control riding along the slab pipeline.
  typedef struct packed {
    logic             last;
    logic             counted;
    logic             too_many;
    logic [IDX_W-1:0] index;
  } box_ctrl_t;

  // One classified box handed from the front to the back.
  typedef struct packed {
    logic                     last;
    logic                     hit;
    logic                     too_many;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] tmin;
  } hit_entry_t;

  typedef struct packed {
    logic               empty;
    logic [FIFO_CW-1:0] count;
  } fifo_stat_t;

  // Clamp a sign-extended value to the signed data range.
  function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [PROD_W-1:0] v);
    logic in_range;
    in_range = (&v[PROD_W-1:DATA_W-1]) | ~(|v[PROD_W-1:DATA_W-1]);
    if (in_range) begin
      return v[DATA_W-1:0];
    end else if (v[PROD_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

// File: design/rbnh_front.sv
// Front end: ray registers, box counting and the four-stage slab pipeline.
module rbnh_front import rbnh_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [DATA_W-1:0]        cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] center_x_i,
  input  logic signed [DATA_W-1:0] center_y_i,
  input  logic signed [DATA_W-1:0] center_z_i,
  input  logic [EXT_W-1:0]         extent_x_i,
  input  logic [EXT_W-1:0]         extent_y_i,
  input  logic [EXT_W-1:0]         extent_z_i,
  input  logic                     last_box_i,
  input  fifo_stat_t               fifo_stat_i,
  output logic                     push_o,
  output hit_entry_t               push_data_o
);

  logic signed [DATA_W-1:0] org_q [NUM_AXES];
  logic signed [DATA_W-1:0] inv_q [NUM_AXES];
  logic signed [DATA_W-1:0] ctr   [NUM_AXES];
  logic [EXT_W-1:0]         ext   [NUM_AXES];

  logic [CNT_W-1:0] box_cnt_q, box_cnt_d;
  logic             accept;
  logic [OCC_W-1:0] occupancy;

  logic        v1_q, v2_q, v3_q, v4_q;
  box_ctrl_t   c1_q, c2_q, c3_q, c1_d;
  hit_entry_t  e4_q, e4_d;

  logic signed [DATA_W-1:0] off_lo_d [NUM_AXES], off_hi_d [NUM_AXES];
  logic signed [DATA_W-1:0] off_lo_q [NUM_AXES], off_hi_q [NUM_AXES];
  logic signed [PROD_W-1:0] p_lo_q   [NUM_AXES], p_hi_q   [NUM_AXES];
  logic signed [DATA_W-1:0] lo_d     [NUM_AXES], hi_d     [NUM_AXES];
  logic signed [DATA_W-1:0] lo_q     [NUM_AXES], hi_q     [NUM_AXES];

  assign ctr[0] = center_x_i;
  assign ctr[1] = center_y_i;
  assign ctr[2] = center_z_i;
  assign ext[0] = extent_x_i;
  assign ext[1] = extent_y_i;
  assign ext[2] = extent_z_i;

  // Credit check: every box in the pipe already owns a queue slot.
  assign occupancy = OCC_W'(fifo_stat_i.count) + OCC_W'(v1_q) + OCC_W'(v2_q)
                   + OCC_W'(v3_q) + OCC_W'(v4_q);
  assign in_stall_o = (occupancy >= OCC_W'(FIFO_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        org_q[a] <= '0;
        inv_q[a] <= INV_DIR_RESET;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ORIGIN_X:  org_q[0] <= cfg_data_i;
        REG_ORIGIN_Y:  org_q[1] <= cfg_data_i;
        REG_ORIGIN_Z:  org_q[2] <= cfg_data_i;
        REG_INV_DIR_X: inv_q[0] <= cfg_data_i;
        REG_INV_DIR_Y: inv_q[1] <= cfg_data_i;
        REG_INV_DIR_Z: inv_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Box counter saturates one past the limit so too_many can be read from it.
  always_comb begin
    box_cnt_d = box_cnt_q;
    if (accept) begin
      if (last_box_i) begin
        box_cnt_d = '0;
      end else if (box_cnt_q <= CNT_W'(MAX_BOXES)) begin
        box_cnt_d = box_cnt_q + CNT_W'(1);
      end
    end
    c1_d.last     = last_box_i;
    c1_d.counted  = (box_cnt_q < CNT_W'(MAX_BOXES));
    c1_d.too_many = (box_cnt_q >= CNT_W'(MAX_BOXES));
    c1_d.index    = IDX_W'(box_cnt_q);
  end

  // Stage 1: plane offsets from the origin, clamped to the data range.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      off_lo_d[a] = sat_word(PROD_W'(OFF_W'(ctr[a])
                    - $signed({{(OFF_W-EXT_W+1){1'b0}}, ext[a][EXT_W-1:1]})
                    - OFF_W'(org_q[a])));
      off_hi_d[a] = sat_word(PROD_W'(OFF_W'(ctr[a])
                    + $signed({{(OFF_W-EXT_W+1){1'b0}}, ext[a][EXT_W-1:1]})
                    - OFF_W'(org_q[a])));
    end
  end

  // Stage 3: floor shift of the products, then order the two planes.
  always_comb begin
    logic signed [DATA_W-1:0] ta, tb;
    for (int a = 0; a < NUM_AXES; a++) begin
      ta = sat_word(p_lo_q[a] >>> FRAC_W);
      tb = sat_word(p_hi_q[a] >>> FRAC_W);
      lo_d[a] = (ta < tb) ? ta : tb;
      hi_d[a] = (ta < tb) ? tb : ta;
    end
  end

  // Stage 4: slab intersection and hit decision.
  always_comb begin
    logic signed [DATA_W-1:0] tmin, tmax;
    tmin = lo_q[0];
    if (lo_q[1] > tmin) tmin = lo_q[1];
    if (lo_q[2] > tmin) tmin = lo_q[2];
    tmax = hi_q[0];
    if (hi_q[1] < tmax) tmax = hi_q[1];
    if (hi_q[2] < tmax) tmax = hi_q[2];
    e4_d.last     = c3_q.last;
    e4_d.too_many = c3_q.too_many;
    e4_d.index    = c3_q.index;
    e4_d.tmin     = tmin;
    e4_d.hit      = c3_q.counted && !tmax[DATA_W-1] && (tmin <= tmax);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_cnt_q <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
    end else begin
      box_cnt_q <= box_cnt_d;
      v1_q      <= accept;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q <= c1_d;
    c2_q <= c1_q;
    c3_q <= c2_q;
    e4_q <= e4_d;
    for (int a = 0; a < NUM_AXES; a++) begin
      off_lo_q[a] <= off_lo_d[a];
      off_hi_q[a] <= off_hi_d[a];
      p_lo_q[a]   <= PROD_W'(off_lo_q[a]) * PROD_W'(inv_q[a]);
      p_hi_q[a]   <= PROD_W'(off_hi_q[a]) * PROD_W'(inv_q[a]);
      lo_q[a]     <= lo_d[a];
      hi_q[a]     <= hi_d[a];
    end
  end

  assign push_o      = v4_q;
  assign push_data_o = e4_q;

endmodule

// File: design/rbnh_fifo.sv
// Short queue of classified boxes between the front and the back.
module rbnh_fifo import rbnh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  hit_entry_t push_data_i,
  input  logic       pop_i,
  output hit_entry_t pop_data_o,
  output fifo_stat_t stat_o
);

  hit_entry_t         mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] cnt_q;
  logic               do_pop;

  // The front never pushes into a full queue, credits see to that.
  assign do_pop = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      unique case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + FIFO_CW'(1);
        2'b01:   cnt_q <= cnt_q - FIFO_CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  assign pop_data_o   = mem_q[rd_ptr_q];
  assign stat_o.count = cnt_q;
  assign stat_o.empty = (cnt_q == '0);

endmodule

// File: design/rbnh_back.sv
// Back end: keeps the nearest hit of the batch and holds the result register.
module rbnh_back import rbnh_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     entry_valid_i,
  input  hit_entry_t               entry_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     hit_found_o,
  output logic [IDX_W-1:0]         closest_index_o,
  output logic signed [DATA_W-1:0] closest_distance_o,
  output logic                     too_many_o
);

  logic                     best_valid_q, best_valid_d;
  logic signed [DATA_W-1:0] best_dist_q, best_dist_d;
  logic [IDX_W-1:0]         best_idx_q, best_idx_d;
  logic                     out_valid_q, out_valid_d;
  logic                     out_hit_q, out_too_many_q;
  logic [IDX_W-1:0]         out_idx_q;
  logic signed [DATA_W-1:0] out_dist_q;
  logic                     better, pop, finish;
  logic                     nb_valid;
  logic signed [DATA_W-1:0] nb_dist;
  logic [IDX_W-1:0]         nb_idx;

  // Only a batch end waits for the result register; other boxes drain freely.
  assign pop    = entry_valid_i && (!entry_i.last || !out_valid_q || !out_stall_i);
  assign finish = pop && entry_i.last;
  // Strict compare: on a tie the earlier box stays.
  assign better = entry_i.hit && (!best_valid_q || (entry_i.tmin < best_dist_q));

  always_comb begin
    nb_valid = best_valid_q || better;
    nb_dist  = better ? entry_i.tmin  : best_dist_q;
    nb_idx   = better ? entry_i.index : best_idx_q;

    best_valid_d = best_valid_q;
    best_dist_d  = best_dist_q;
    best_idx_d   = best_idx_q;
    if (finish) begin
      best_valid_d = 1'b0;
      best_dist_d  = '0;
      best_idx_d   = '0;
    end else if (pop) begin
      best_valid_d = nb_valid;
      best_dist_d  = nb_dist;
      best_idx_d   = nb_idx;
    end

    priority if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_valid_q <= 1'b0;
      best_dist_q  <= '0;
      best_idx_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      best_valid_q <= best_valid_d;
      best_dist_q  <= best_dist_d;
      best_idx_q   <= best_idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Best state is zero while nothing was hit, so no masking is needed here.
  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_hit_q      <= nb_valid;
      out_idx_q      <= nb_idx;
      out_dist_q     <= nb_dist;
      out_too_many_q <= entry_i.too_many;
    end
  end

  assign pop_o              = pop;
  assign out_valid_o        = out_valid_q;
  assign hit_found_o        = out_hit_q;
  assign closest_index_o    = out_idx_q;
  assign closest_distance_o = out_dist_q;
  assign too_many_o         = out_too_many_q;

endmodule

// File: design/ray_box_nearest_hit.sv
// Top level of the ray/box nearest hit block.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------------
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in      | in        | in_valid/in_stall    | center_x/y/z, extent_x/y/z, last_box
//   out     | out       | out_valid/out_stall  | hit_found, closest_index/distance, too_many
//
// One box per cycle while in_stall is low; the four-stage slab pipeline (offset, multiply,
// shift and order, intersect) feeds an 8-entry queue, which the back end drains into the
// result register.
// Boxes are admitted by credit: at most 8 in pipe and queue, so in_stall only rises
// while a finished result is pending in the output register.
// Reset restores the ray registers to defaults and empties the pipe; no clearing pass.
// Configuration writes are taken every cycle.
module ray_box_nearest_hit import rbnh_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [DATA_W-1:0]        cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] center_x_i,
  input  logic signed [DATA_W-1:0] center_y_i,
  input  logic signed [DATA_W-1:0] center_z_i,
  input  logic [EXT_W-1:0]         extent_x_i,
  input  logic [EXT_W-1:0]         extent_y_i,
  input  logic [EXT_W-1:0]         extent_z_i,
  input  logic                     last_box_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     hit_found_o,
  output logic [IDX_W-1:0]         closest_index_o,
  output logic signed [DATA_W-1:0] closest_distance_o,
  output logic                     too_many_o
);

  fifo_stat_t fifo_stat;
  logic       push, pop;
  hit_entry_t push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  rbnh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .center_z_i  (center_z_i),
    .extent_x_i  (extent_x_i),
    .extent_y_i  (extent_y_i),
    .extent_z_i  (extent_z_i),
    .last_box_i  (last_box_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  rbnh_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (fifo_stat)
  );

  rbnh_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .entry_valid_i      (!fifo_stat.empty),
    .entry_i            (pop_data),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .hit_found_o        (hit_found_o),
    .closest_index_o    (closest_index_o),
    .closest_distance_o (closest_distance_o),
    .too_many_o         (too_many_o)
  );

endmodule

// File: design/rbnh_checker.sv
// Port-level checks of the ray/box nearest hit block and their binding.
`include "ray_box_nearest_hit_defines.svh"

module rbnh_checker import rbnh_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic                     hit_found_o,
  input logic [IDX_W-1:0]         closest_index_o,
  input logic signed [DATA_W-1:0] closest_distance_o,
  input logic                     too_many_o
);

  `RBNH_ASSERT_NEXT(a_out_valid_holds, out_valid_o && out_stall_i, out_valid_o, "out_valid dropped while stalled")
  `RBNH_ASSERT_NEXT(a_out_payload_holds, out_valid_o && out_stall_i, $stable(hit_found_o) && $stable(closest_index_o) && $stable(closest_distance_o) && $stable(too_many_o), "stalled result changed")
  `RBNH_ASSERT_NOW(a_miss_is_zero, out_valid_o && !hit_found_o, (closest_index_o == '0) && (closest_distance_o == '0), "miss result not zero")
  // The queue only fills up behind a result that is waiting to be taken.
  `RBNH_ASSERT_NOW(a_stall_needs_result, in_stall_o, out_valid_o, "input stalled with no result pending")

endmodule

bind ray_box_nearest_hit rbnh_checker u_rbnh_checker (.*);

// File: test/tb_ray_box_nearest_hit.sv
// Self-checking testbench for the ray/box nearest hit block.
`timescale 1ns / 1ps

module tb_ray_box_nearest_hit;
  import rbnh_pkg::*;

  localparam int STALL_LIMIT = 5000;   // cycles with no transaction at all
  localparam int DRAIN_TAIL  = 12;     // idle wait after the last result is taken
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_BOXES   = 35;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic signed [DATA_W-1:0] W_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] W_MIN   = 32'sh8000_0000;
  localparam logic [DATA_W-1:0]        EXT_MAX = 32'h7FFF_FFFF;

  typedef struct {
    logic signed [DATA_W-1:0] c [3];
    logic [EXT_W-1:0]         e [3];
    logic                     last;
  } box_t;

  typedef struct {
    logic              hit;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] distance;
    logic              over;
  } nearest_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic signed [DATA_W-1:0] center_x = '0;
  logic signed [DATA_W-1:0] center_y = '0;
  logic signed [DATA_W-1:0] center_z = '0;
  logic [EXT_W-1:0]         extent_x = '0;
  logic [EXT_W-1:0]         extent_y = '0;
  logic [EXT_W-1:0]         extent_z = '0;
  logic                     last_box = 1'b0;
  logic                     out_stall = 1'b0;

  logic                     cfg_ready_o;
  logic                     in_stall_o;
  logic                     out_valid_o;
  logic                     hit_found_o;
  logic [IDX_W-1:0]         closest_index_o;
  logic signed [DATA_W-1:0] closest_distance_o;
  logic                     too_many_o;

  ray_box_nearest_hit u_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall_o),
    .center_x_i         (center_x),
    .center_y_i         (center_y),
    .center_z_i         (center_z),
    .extent_x_i         (extent_x),
    .extent_y_i         (extent_y),
    .extent_z_i         (extent_z),
    .last_box_i         (last_box),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall),
    .hit_found_o        (hit_found_o),
    .closest_index_o    (closest_index_o),
    .closest_distance_o (closest_distance_o),
    .too_many_o         (too_many_o)
  );

  // Shadow of the ray registers and the running nearest hit.
  longint      ray_org [3];
  longint      ray_inv [3];
  bit          best_hit;
  longint      best_t;
  int unsigned best_pos;
  int unsigned box_count;
  nearest_t    nearest_q [$];

  int  errors = 0;
  int  boxes_sent = 0;
  int  results_seen = 0;
  int  hits_seen = 0;
  int  over_seen = 0;
  int  settings_used = 0;
  bit  send_idle = 1'b1;
  bit  recv_idle = 1'b1;
  int  hold_len = 0;
  int  hold_reqs = 0;
  int  hold_taken = 0;
  int  hold_left = 0;
  int  idle_cycles = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Ray parameter at one slab plane, floor division by 2^16.
  function automatic longint plane_param(longint bound, longint org, longint inv);
    longint off;
    off = clamp32(bound - org);
    return clamp32((off * inv) >>> FRAC_W);
  endfunction

  function automatic void trace_box(box_t b);
    longint   lo [3];
    longint   hi [3];
    longint   ta, tb, half, tmin, tmax;
    nearest_t r;
    if (box_count < MAX_BOXES) begin
      for (int a = 0; a < 3; a++) begin
        half = longint'(b.e[a] >> 1);
        ta = plane_param(longint'(b.c[a]) - half, ray_org[a], ray_inv[a]);
        tb = plane_param(longint'(b.c[a]) + half, ray_org[a], ray_inv[a]);
        lo[a] = (ta < tb) ? ta : tb;
        hi[a] = (ta < tb) ? tb : ta;
      end
      tmin = lo[0];
      if (lo[1] > tmin) tmin = lo[1];
      if (lo[2] > tmin) tmin = lo[2];
      tmax = hi[0];
      if (hi[1] < tmax) tmax = hi[1];
      if (hi[2] < tmax) tmax = hi[2];
      // strict compare: on a tie the first box stays
      if (tmax >= 0 && tmin <= tmax && (!best_hit || tmin < best_t)) begin
        best_hit = 1'b1;
        best_t   = tmin;
        best_pos = box_count;
      end
      box_count++;
    end else if (box_count == MAX_BOXES) begin
      box_count++;
    end
    if (b.last) begin
      r.hit      = best_hit;
      r.index    = best_hit ? best_pos[IDX_W-1:0] : '0;
      r.distance = best_hit ? best_t[DATA_W-1:0] : '0;
      r.over     = (box_count > MAX_BOXES);
      nearest_q.push_back(r);
      best_hit  = 1'b0;
      best_t    = 0;
      best_pos  = 0;
      box_count = 0;
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] fix(int n);
    return DATA_W'(n) <<< FRAC_W;
  endfunction

  function automatic box_t make_box(logic signed [DATA_W-1:0] cx, logic signed [DATA_W-1:0] cy,
                                    logic signed [DATA_W-1:0] cz, logic [DATA_W-1:0] ex,
                                    logic [DATA_W-1:0] ey, logic [DATA_W-1:0] ez, logic last);
    box_t b;
    b.c[0] = cx;
    b.c[1] = cy;
    b.c[2] = cz;
    b.e[0] = ex[EXT_W-1:0];
    b.e[1] = ey[EXT_W-1:0];
    b.e[2] = ez[EXT_W-1:0];
    b.last = last;
    return b;
  endfunction

  // Box placed near a random point along the current ray.
  function automatic box_t aimed_box();
    box_t   b;
    longint t, dir, c;
    t = longint'($urandom_range(0, 64 << FRAC_W));
    if ($urandom_range(0, 9) == 0) t = -t;   // behind the origin
    for (int a = 0; a < 3; a++) begin
      dir = (ray_inv[a] == 0) ? 0 : ((longint'(1) <<< 32) / ray_inv[a]);
      c = ray_org[a] + ((t * dir) >>> FRAC_W)
          + longint'($urandom_range(0, 1 << 19)) - longint'(1 << 18);
      b.c[a] = DATA_W'(clamp32(c));
      b.e[a] = EXT_W'($urandom_range(0, 1 << 21));
    end
    b.last = 1'b0;
    return b;
  endfunction

  function automatic box_t noise_box();
    box_t b;
    for (int a = 0; a < 3; a++) begin
      b.c[a] = $urandom;
      b.e[a] = EXT_W'($urandom);
    end
    b.last = 1'b0;
    return b;
  endfunction

  function automatic logic [DATA_W-1:0] rand_origin();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) return $urandom;
    if (kind == 1) return $urandom_range(0, 1) ? W_MAX : W_MIN;
    return DATA_W'(longint'($urandom_range(0, 1 << 25)) - longint'(1 << 24));
  endfunction

  function automatic logic [DATA_W-1:0] rand_inv();
    int     kind;
    longint mag;
    kind = $urandom_range(0, 9);
    if (kind == 0) return '0;
    if (kind == 1) return $urandom_range(0, 1) ? W_MAX : W_MIN;
    if (kind == 2) return $urandom;
    mag = longint'($urandom_range(1 << 14, 1 << 18));
    return DATA_W'($urandom_range(0, 1) ? mag : -mag);
  endfunction

  // Sender stops and waits until every batch result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic send_box(box_t b);
    if (send_idle && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    center_x <= b.c[0];
    center_y <= b.c[1];
    center_z <= b.c[2];
    extent_x <= b.e[0];
    extent_y <= b.e[1];
    extent_z <= b.e[2];
    last_box <= b.last;
    do @(posedge clk); while (in_stall_o);
    trace_box(b);
    boxes_sent++;
  endtask

  // Writes all six ray registers, then one unmapped index that must be ignored.
  task automatic program_ray(input logic [DATA_W-1:0] ox, input logic [DATA_W-1:0] oy,
                             input logic [DATA_W-1:0] oz, input logic [DATA_W-1:0] ix,
                             input logic [DATA_W-1:0] iy, input logic [DATA_W-1:0] iz);
    logic [DATA_W-1:0]    vals [6];
    logic [CFG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    word;
    vals[0] = ox;
    vals[1] = oy;
    vals[2] = oz;
    vals[3] = ix;
    vals[4] = iy;
    vals[5] = iz;
    wait_drained();
    for (int i = 0; i < 7; i++) begin
      if (i < 6) begin
        idx  = cfg_reg_e'(i);
        word = vals[i];
      end else begin
        idx  = $urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO;
        word = $urandom;
      end
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= word;
      do @(posedge clk); while (!cfg_ready_o);
      case (idx)
        REG_ORIGIN_X:  ray_org[0] = longint'($signed(word));
        REG_ORIGIN_Y:  ray_org[1] = longint'($signed(word));
        REG_ORIGIN_Z:  ray_org[2] = longint'($signed(word));
        REG_INV_DIR_X: ray_inv[0] = longint'($signed(word));
        REG_INV_DIR_Y: ray_inv[1] = longint'($signed(word));
        REG_INV_DIR_Z: ray_inv[2] = longint'($signed(word));
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Hand-picked boxes: inside hits, ties, misses, field extremes, zero and
  // saturated reciprocals, saturated offsets.
  task automatic test_corner_boxes();
    program_ray('0, '0, '0, INV_DIR_RESET, INV_DIR_RESET, INV_DIR_RESET);
    send_box(make_box(fix(5), fix(5), fix(5), fix(2), fix(2), fix(2), 1'b0));
    send_box(make_box(fix(3), fix(3), fix(3), fix(2), fix(2), fix(2), 1'b0));
    send_box(make_box('0, '0, '0, fix(4), fix(4), fix(4), 1'b0));
    send_box(make_box('0, '0, '0, fix(4), fix(4), fix(4), 1'b1));
    send_box(make_box(fix(-10), fix(-10), fix(-10), fix(2), fix(2), fix(2), 1'b1));
    send_box(make_box(fix(5), fix(-5), fix(5), fix(2), fix(2), fix(2), 1'b0));
    send_box(make_box(fix(5), fix(10), fix(5), fix(2), fix(2), fix(2), 1'b1));
    send_box(make_box(W_MAX, W_MAX, W_MAX, EXT_MAX, EXT_MAX, EXT_MAX, 1'b0));
    send_box(make_box(W_MIN, W_MIN, W_MIN, '0, '0, '0, 1'b0));
    send_box(make_box(W_MIN, W_MAX, W_MIN, EXT_MAX, EXT_MAX, EXT_MAX, 1'b0));
    send_box(make_box(fix(7), fix(7), fix(7), '0, '0, '0, 1'b1));

    program_ray('0, '0, '0, '0, INV_DIR_RESET, INV_DIR_RESET);
    send_box(make_box(fix(100), fix(5), fix(5), fix(2), fix(2), fix(2), 1'b0));
    send_box(make_box(fix(100), '0, '0, fix(2), fix(2), fix(2), 1'b1));

    program_ray('0, '0, '0, INV_DIR_RESET, W_MAX, W_MIN);
    send_box(make_box('0, '0, '0, fix(2), fix(2), fix(2), 1'b0));
    send_box(make_box(fix(1), fix(1), fix(-1), fix(1), fix(1), fix(1), 1'b1));

    program_ray(W_MIN, W_MAX, W_MIN, INV_DIR_RESET, INV_DIR_RESET, INV_DIR_RESET);
    send_box(make_box(W_MAX, W_MAX, W_MAX, EXT_MAX, EXT_MAX, EXT_MAX, 1'b0));
    send_box(make_box(W_MIN, W_MIN, W_MIN, EXT_MAX, EXT_MAX, EXT_MAX, 1'b0));
    send_box(make_box('0, '0, '0, EXT_MAX, EXT_MAX, EXT_MAX, 1'b1));
  endtask

  // One batch past the limit, sent with no gaps; a near box after the limit
  // must be ignored.
  task automatic test_box_limit();
    box_t b;
    program_ray('0, '0, '0, INV_DIR_RESET, INV_DIR_RESET, INV_DIR_RESET);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    for (int k = 0; k < MAX_BOXES + 2; k++) begin
      if (k == MAX_BOXES) b = make_box('0, '0, '0, EXT_MAX, EXT_MAX, EXT_MAX, 1'b0);
      else b = aimed_box();
      b.last = (k == MAX_BOXES + 1);
      send_box(b);
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  // Receiver holds off while short batches keep coming, so the input stalls.
  task automatic test_backpressure();
    box_t b;
    program_ray(rand_origin(), rand_origin(), rand_origin(),
                INV_DIR_RESET, INV_DIR_RESET, INV_DIR_RESET);
    hold_len = 120;
    hold_reqs++;
    for (int k = 0; k < 48; k++) begin
      b = aimed_box();
      b.last = (k % 3 == 2);
      send_box(b);
    end
    wait_drained();
  endtask

  task automatic test_random_batches();
    box_t b, prev;
    int   sent, len, pick;
    prev = noise_box();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      program_ray(rand_origin(), rand_origin(), rand_origin(), rand_inv(), rand_inv(), rand_inv());
      send_idle = (p != 3);
      recv_idle = (p != 3);
      sent = 0;
      while (sent < PHASE_BOXES) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 10 && k > 0) b = prev;   // repeated box gives a tie
          else if (pick < 25) b = noise_box();
          else b = aimed_box();
          b.last = (k == len - 1);
          send_box(b);
          prev = b;
          sent++;
        end
      end
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_taken != hold_reqs) begin
      hold_taken = hold_reqs;
      hold_left  = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (recv_idle) begin
      out_stall <= ($urandom_range(0, 99) < 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_result
    nearest_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (nearest_q.size() == 0) begin
        report_mismatch("result with nothing expected", DATA_W'(hit_found_o), '0);
      end else begin
        want = nearest_q.pop_front();
        if (hit_found_o !== want.hit)
          report_mismatch("hit_found", DATA_W'(hit_found_o), DATA_W'(want.hit));
        if (closest_index_o !== want.index)
          report_mismatch("closest_index", DATA_W'(closest_index_o), DATA_W'(want.index));
        if (closest_distance_o !== want.distance)
          report_mismatch("closest_distance", closest_distance_o, want.distance);
        if (too_many_o !== want.over)
          report_mismatch("too_many", DATA_W'(too_many_o), DATA_W'(want.over));
        results_seen++;
        if (want.hit) hits_seen++;
        if (want.over) over_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || (cfg_valid && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] no transaction for %0d cycles", $realtime, STALL_LIMIT);
      $display("FAIL ray_box_nearest_hit");
      $finish;
    end
  end

  initial begin
    for (int a = 0; a < 3; a++) begin
      ray_org[a] = 0;
      ray_inv[a] = longint'(INV_DIR_RESET);
    end
    best_hit  = 1'b0;
    best_t    = 0;
    best_pos  = 0;
    box_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_boxes();
    test_box_limit();
    test_backpressure();
    test_random_batches();
    wait_drained();

    $display("covered %0d boxes in %0d batches (%0d with a hit, %0d over the box limit)",
             boxes_sent, results_seen, hits_seen, over_seen);
    $display("across %0d ray settings, with input gaps, output stalls and a long hold-off",
             settings_used);
    if (errors == 0) begin
      $display("PASS ray_box_nearest_hit");
    end else begin
      $display("FAIL ray_box_nearest_hit");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/rbnh_pkg.sv
design/rbnh_front.sv
design/rbnh_fifo.sv
design/rbnh_back.sv
design/ray_box_nearest_hit.sv
design/rbnh_checker.sv
test/tb_ray_box_nearest_hit.sv
